// ----- src/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, constants and the microcode program of the power-by-squaring
// block.
// ----------------------------------------------------------------------------
package pbs_pkg;

   // Width of every payload field on the channels.
   localparam int FIELD_BITS = 64;

   // Default arithmetic word width of the block.
   localparam int WORD_BITS_DEFAULT = 64;

   // Width of the microcode step counter.
   localparam int STEP_BITS = 4;

   typedef logic [FIELD_BITS-1:0] field_type;

   // Microcode steps, in program order.
   typedef enum logic [STEP_BITS-1:0] {
      STEP_IDLE,
      STEP_SQ_LL,
      STEP_SQ_LH,
      STEP_SQ_HL,
      STEP_SQ_END,
      STEP_MU_LL,
      STEP_MU_LH,
      STEP_MU_HL,
      STEP_MU_END,
      STEP_NEXT,
      STEP_DONE
   } step_type;

   // First multiplier operand: a half of the accumulator.
   typedef enum logic {
      A_ACC_LO,
      A_ACC_HI
   } mul_a_sel_type;

   // Second multiplier operand: a half of the accumulator or of the base.
   typedef enum logic [1:0] {
      B_ACC_LO,
      B_ACC_HI,
      B_BASE_LO,
      B_BASE_HI
   } mul_b_sel_type;

   // Partial sum update.
   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD,
      SUM_ADD
   } sum_op_type;

   // Handshake that a step waits for before it moves on.
   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_RSP
   } wait_type;

   // Jump condition, tested once the step may move on.
   typedef enum logic [1:0] {
      JUMP_NONE,
      JUMP_ALWAYS,
      JUMP_EXP_CLEAR,
      JUMP_MORE_BITS
   } jump_type;

   // One control word of the program.
   typedef struct packed {
      wait_type      wait_mode;
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      sum_op_type    sum_op;
      logic          acc_write;
      logic          bit_step;
      jump_type      jump;
      step_type      target;
   } ctrl_word_type;

   // Status returned from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic rsp_ready;
      logic exp_bit;
      logic more_bits;
   } status_type;

   // The program: a square of the accumulator, an optional multiply by the
   // base, then a step to the next exponent bit.
   function automatic ctrl_word_type microcode(step_type step);
      ctrl_word_type word;
      word.wait_mode = WAIT_NONE;
      word.mul_a     = A_ACC_LO;
      word.mul_b     = B_ACC_LO;
      word.sum_op    = SUM_HOLD;
      word.acc_write = 1'b0;
      word.bit_step  = 1'b0;
      word.jump      = JUMP_NONE;
      word.target    = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            word.wait_mode = WAIT_REQ;
         end
         STEP_SQ_LL: begin
            word.mul_a = A_ACC_LO;
            word.mul_b = B_ACC_LO;
         end
         STEP_SQ_LH: begin
            word.mul_a  = A_ACC_LO;
            word.mul_b  = B_ACC_HI;
            word.sum_op = SUM_LOAD;
         end
         STEP_SQ_HL: begin
            word.mul_a  = A_ACC_HI;
            word.mul_b  = B_ACC_LO;
            word.sum_op = SUM_ADD;
         end
         STEP_SQ_END: begin
            word.acc_write = 1'b1;
            word.jump      = JUMP_EXP_CLEAR;
            word.target    = STEP_NEXT;
         end
         STEP_MU_LL: begin
            word.mul_a = A_ACC_LO;
            word.mul_b = B_BASE_LO;
         end
         STEP_MU_LH: begin
            word.mul_a  = A_ACC_LO;
            word.mul_b  = B_BASE_HI;
            word.sum_op = SUM_LOAD;
         end
         STEP_MU_HL: begin
            word.mul_a  = A_ACC_HI;
            word.mul_b  = B_BASE_LO;
            word.sum_op = SUM_ADD;
         end
         STEP_MU_END: begin
            word.acc_write = 1'b1;
         end
         STEP_NEXT: begin
            word.bit_step = 1'b1;
            word.jump     = JUMP_MORE_BITS;
            word.target   = STEP_SQ_LL;
         end
         STEP_DONE: begin
            word.wait_mode = WAIT_RSP;
            word.jump      = JUMP_ALWAYS;
            word.target    = STEP_IDLE;
         end
         default: begin
            word.jump   = JUMP_ALWAYS;
            word.target = STEP_IDLE;
         end
      endcase
      return word;
   endfunction

endpackage

// ----- src/pbs_req_if.sv -----
// ----------------------------------------------------------------------------
// pbs_req_if
// Request channel: a base and an exponent under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbs_req_if
   import pbs_pkg::*;
   ();

   logic      valid;
   logic      ready;
   field_type base;
   field_type exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);

endinterface

// ----- src/pbs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pbs_rsp_if
// Response channel: the power under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbs_rsp_if
   import pbs_pkg::*;
   ();

   logic      valid;
   logic      ready;
   field_type power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);

endinterface

// ----- src/power_by_squaring_64.sv -----
// ----------------------------------------------------------------------------
// power_by_squaring_64
// Base raised to an exponent modulo 2^WORD_BITS, by left-to-right
// square-and-multiply under microcode control.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one response.
// Every exponent bit, from the most significant down, costs a square of the
// accumulator (steps SQ_LL to SQ_END) and, where the bit is set, a multiply
// by the base (steps MU_LL to MU_END), then the bit step (STEP_NEXT). The
// next request can be taken from the cycle after the response is taken. A
// single half-width multiplier forms each product from three partial
// products (LL, LH and HL). Input bits above WORD_BITS are ignored and the
// power's bits above WORD_BITS are zero.
// ----------------------------------------------------------------------------
module power_by_squaring_64
   import pbs_pkg::*;
   #(
      parameter int WORD_BITS = WORD_BITS_DEFAULT
   )
   (
      input  logic         clock,
      input  logic         reset,
      pbs_req_if.sink      req,
      pbs_rsp_if.source    rsp
   );

   localparam int HALF_BITS  = (WORD_BITS + 1) / 2;
   localparam int HI_BITS    = WORD_BITS - HALF_BITS;
   localparam int PROD_BITS  = 2 * HALF_BITS;
   localparam int COUNT_BITS = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [HALF_BITS-1:0]  half_type;
   typedef logic [PROD_BITS-1:0]  prod_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   ctrl_word_type ctrl;
   status_type    status;

   word_type  base_ff;
   word_type  exp_ff;
   word_type  exp_in;
   word_type  acc_ff;
   word_type  acc_in;
   word_type  sum_ff;
   word_type  sum_in;
   prod_type  prod_ff;
   prod_type  prod_in;
   count_type count_ff;
   count_type count_in;

   half_type  acc_lo;
   half_type  acc_hi;
   half_type  base_lo;
   half_type  base_hi;
   half_type  mul_a;
   half_type  mul_b;
   word_type  merged;
   logic      accept;

   pbs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Handshakes follow the wait mode of the current step.
   assign req.ready = (ctrl.wait_mode == WAIT_REQ);
   assign rsp.valid = (ctrl.wait_mode == WAIT_RSP);
   assign rsp.power = field_type'(acc_ff);
   assign accept    = req.valid && req.ready;

   assign status.req_valid = req.valid;
   assign status.rsp_ready = rsp.ready;
   assign status.exp_bit   = exp_ff[WORD_BITS-1];
   assign status.more_bits = (count_ff != '0);

   // Operand halves; the upper halves are zero-extended.
   assign acc_lo  = acc_ff[HALF_BITS-1:0];
   assign acc_hi  = half_type'(acc_ff[WORD_BITS-1:HALF_BITS]);
   assign base_lo = base_ff[HALF_BITS-1:0];
   assign base_hi = half_type'(base_ff[WORD_BITS-1:HALF_BITS]);

   // Multiplier operand selection.
   always_comb begin
      case (ctrl.mul_a)
         A_ACC_LO: mul_a = acc_lo;
         A_ACC_HI: mul_a = acc_hi;
         default:  mul_a = acc_lo;
      endcase
      case (ctrl.mul_b)
         B_ACC_LO:  mul_b = acc_lo;
         B_ACC_HI:  mul_b = acc_hi;
         B_BASE_LO: mul_b = base_lo;
         B_BASE_HI: mul_b = base_hi;
         default:   mul_b = acc_lo;
      endcase
   end

   // Half-width multiplier; its product is registered before use.
   assign prod_in = prod_type'(mul_a) * prod_type'(mul_b);

   // Running sum plus the registered cross product moved up by a half word.
   assign merged = sum_ff + {prod_ff[HI_BITS-1:0], half_type'(0)};

   // Partial sum update.
   always_comb begin
      case (ctrl.sum_op)
         SUM_HOLD: sum_in = sum_ff;
         SUM_LOAD: sum_in = prod_ff[WORD_BITS-1:0];
         SUM_ADD:  sum_in = merged;
         default:  sum_in = sum_ff;
      endcase
   end

   // Accumulator, exponent and bit count: loaded on a request, stepped by
   // the program.
   always_comb begin
      acc_in   = acc_ff;
      exp_in   = exp_ff;
      count_in = count_ff;
      if (accept) begin
         acc_in   = word_type'(1);
         exp_in   = req.exponent[WORD_BITS-1:0];
         count_in = count_type'(WORD_BITS - 1);
      end else begin
         if (ctrl.acc_write) begin
            acc_in = merged;
         end
         if (ctrl.bit_step) begin
            exp_in   = {exp_ff[WORD_BITS-2:0], 1'b0};
            count_in = count_ff - count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= req.base[WORD_BITS-1:0];
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The block never takes a request while it offers a response.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request taken while a response is offered");

   // An accepted request starts from an accumulator of one at the top bit.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (acc_ff == word_type'(1)) && (count_ff == count_type'(WORD_BITS - 1)))
      else $error("accumulator or bit count not initialised on a request");

   // A response is offered only once every exponent bit has been shifted out.
   a_all_bits: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (exp_ff == '0))
      else $error("response offered before the last exponent bit");

   // Each bit step moves the count down by exactly one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.bit_step |=> (count_ff == count_type'($past(count_ff) - count_type'(1))))
      else $error("bit count did not step down by one");
`endif

endmodule

// ----- src/pbs_sequencer.sv -----
// ----------------------------------------------------------------------------
// pbs_sequencer
// Step counter over the microcode program, with handshake waits and
// conditional jumps.
// ----------------------------------------------------------------------------
module pbs_sequencer
   import pbs_pkg::*;
   (
      input  logic          clock,
      input  logic          reset,
      input  status_type    status,
      output ctrl_word_type ctrl
   );

   step_type step_ff;
   step_type step_in;
   logic     advance;
   logic     taken;

   // Control word of the current step.
   assign ctrl = microcode(step_ff);

   // A step that waits for a handshake holds until it completes.
   always_comb begin
      case (ctrl.wait_mode)
         WAIT_NONE: advance = 1'b1;
         WAIT_REQ:  advance = status.req_valid;
         WAIT_RSP:  advance = status.rsp_ready;
         default:   advance = 1'b1;
      endcase
   end

   // Jump condition of the current step.
   always_comb begin
      case (ctrl.jump)
         JUMP_NONE:      taken = 1'b0;
         JUMP_ALWAYS:    taken = 1'b1;
         JUMP_EXP_CLEAR: taken = !status.exp_bit;
         JUMP_MORE_BITS: taken = status.more_bits;
         default:        taken = 1'b0;
      endcase
   end

   // Next step: hold, jump or fall through.
   always_comb begin
      if (!advance) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(STEP_BITS'(step_ff) + STEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
